// ----- design/ibrd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibrd_pkg
// Shared types and constants for the interleaved binary range decoder.
// ----------------------------------------------------------------------------
package ibrd_pkg;

    localparam int LANES        = 16;
    localparam int LANE_W       = $clog2(LANES);
    localparam int MODEL_STATES = 32768;
    localparam int ST_W         = $clog2(MODEL_STATES);
    localparam int TR_DEPTH     = 2 * MODEL_STATES;
    localparam int TR_W         = ST_W + 1;
    localparam int CTX_DEPTH    = 256;
    localparam int CTX_AW       = $clog2(CTX_DEPTH);

    localparam int ADDR_W       = 16;
    localparam int STATE_W      = 15;
    localparam int PROB_W       = 15;
    localparam int RANGE_W      = 32;
    localparam int REFILL_W     = 16;
    localparam int TREE_W       = 9;
    localparam int BITCNT_W     = 3;
    localparam int LANE_OUT_W   = 6;
    localparam int USED_W       = 2;
    localparam int BYTE_W       = 8;
    localparam int PROB_SHIFT   = 15;

    localparam int S_TDATA_W    = 80;
    localparam int M_TDATA_W    = 24;

    localparam logic [RANGE_W-1:0] RANGE_FULL = 32'hFFFF_FFFF;
    localparam logic [RANGE_W-1:0] RENORM_ONE = 32'h0100_0000;
    localparam logic [RANGE_W-1:0] RENORM_TWO = 32'h0001_0000;
    localparam logic [TREE_W-1:0]  TREE_ROOT  = 9'd1;
    localparam logic [BITCNT_W-1:0] BIT_LAST  = 3'd7;

    typedef enum logic [1:0] {
        OP_PROB_WR   = 2'd0,
        OP_TRANS_WR  = 2'd1,
        OP_LANE_LOAD = 2'd2,
        OP_DECODE    = 2'd3
    } ibrd_op_t;

    typedef struct packed {
        ibrd_op_t            op;
        logic [ADDR_W-1:0]   address;
        logic [STATE_W-1:0]  table_value;
        logic [RANGE_W-1:0]  initial_code;
        logic [REFILL_W-1:0] refill_bytes;
    } ibrd_item_t;

    typedef struct packed {
        logic                  decoded_bit;
        logic [LANE_OUT_W-1:0] lane;
        logic [USED_W-1:0]     bytes_used;
        logic                  byte_done;
        logic [BYTE_W-1:0]     decoded_byte;
    } ibrd_result_t;

endpackage

// ----- design/ibrd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibrd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ibrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/ibrd_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibrd_out_buf
// Two-entry result buffer in front of the master stream port.
// ----------------------------------------------------------------------------
module ibrd_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ibrd_pkg::ibrd_result_t push_data,
    output logic                  space,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ibrd_pkg::ibrd_result_t head
);
    import ibrd_pkg::*;

    logic [1:0]   count_reg, count_next;
    ibrd_result_t head_reg, head_next;
    ibrd_result_t tail_reg, tail_next;
    logic         pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign head      = head_reg;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next  = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    head_next = push_data;
                end
                else if (push)
                begin
                    tail_next  = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_next = tail_reg;
                    if (push)
                    begin
                        tail_next = push_data;
                    end
                    else
                    begin
                        count_next = 2'd1;
                    end
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("result pushed into a full buffer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_hold_unpopped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(head_reg)))
        else $error("waiting result changed before transfer");

endmodule

// ----- design/ibrd_bit_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibrd_bit_pipe
// Table and lane memories plus the four-stage bit decode pipeline.
// ----------------------------------------------------------------------------
module ibrd_bit_pipe (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_accept,
    input  ibrd_pkg::ibrd_item_t   item,
    output logic                   busy,
    output logic                   res_valid,
    output ibrd_pkg::ibrd_result_t res
);
    import ibrd_pkg::*;

    // operation strobes
    logic prob_we, trans_op_we, load_op, start;

    // control state
    logic [TREE_W-1:0]   tree_reg, tree_next;
    logic [LANE_W-1:0]   lane_cnt_reg, lane_cnt_next;
    logic [BITCNT_W-1:0] bit_cnt_reg;
    logic [LANES-1:0]     lane_valid_reg;
    logic [CTX_DEPTH-1:0] ctx_valid_reg;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    // stage payload
    logic [LANE_W-1:0]   lane_s1_reg, lane_s2_reg, lane_s3_reg;
    logic [CTX_AW-1:0]   cx_s1_reg, cx_s2_reg, cx_s3_reg, cx_s4_reg;
    logic [REFILL_W-1:0] refill_s1_reg, refill_s2_reg, refill_s3_reg;
    logic                lane_vld_s1_reg, ctx_vld_s1_reg;
    logic [ST_W-1:0]     st_s2_reg, st_s3_reg;
    logic [RANGE_W-1:0]  range_s2_reg, code_s2_reg;
    logic [RANGE_W-1:0]  range_s3_reg, code_s3_reg, rp_s3_reg;

    // memory ports
    logic                  lane_we;
    logic [LANE_W-1:0]     lane_waddr;
    logic [2*RANGE_W-1:0]  lane_wdata, lane_rdata;
    logic [STATE_W-1:0]    ctx_rdata;
    logic [PROB_W-1:0]     prob_rdata;
    logic [STATE_W-1:0]    trans_rdata;
    logic [TR_W-1:0]       trans_raddr;
    logic [ST_W-1:0]       st_s1;
    logic [CTX_AW-1:0]     cx_now;

    // stage 3 arithmetic
    logic                  bit_s3;
    logic [RANGE_W-1:0]    r_mid, c_mid, r_new, c_new;
    logic                  below_one, below_two;
    logic [USED_W-1:0]     used_s3;
    logic [TREE_W-1:0]     tree_bit;

    always_comb
    begin
        prob_we     = 1'b0;
        trans_op_we = 1'b0;
        load_op     = 1'b0;
        start       = 1'b0;
        case (item.op)
            OP_PROB_WR:   prob_we     = item_accept;
            OP_TRANS_WR:  trans_op_we = item_accept;
            OP_LANE_LOAD: load_op     = item_accept && (item.address < ADDR_W'(LANES));
            OP_DECODE:    start       = item_accept;
            default:      start       = 1'b0;
        endcase
    end

    assign busy   = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign cx_now = tree_reg[CTX_AW-1:0];

    // lane write: a decode in stage 3 or a lane load, never both at once
    always_comb
    begin
        if (s3_valid_reg)
        begin
            lane_we    = 1'b1;
            lane_waddr = lane_s3_reg;
            lane_wdata = {r_new, c_new};
        end
        else
        begin
            lane_we    = load_op;
            lane_waddr = item.address[LANE_W-1:0];
            lane_wdata = {RANGE_FULL, item.initial_code};
        end
    end

    ibrd_ram #(.WIDTH(2*RANGE_W), .DEPTH(LANES)) u_lane_ram (
        .clk   (clk),
        .we    (lane_we),
        .waddr (lane_waddr),
        .wdata (lane_wdata),
        .raddr (lane_cnt_reg),
        .rdata (lane_rdata)
    );

    ibrd_ram #(.WIDTH(STATE_W), .DEPTH(CTX_DEPTH)) u_ctx_ram (
        .clk   (clk),
        .we    (s4_valid_reg),
        .waddr (cx_s4_reg),
        .wdata (trans_rdata),
        .raddr (cx_now),
        .rdata (ctx_rdata)
    );

    // model state of a context that was never written reads as zero
    assign st_s1 = ctx_vld_s1_reg ? ctx_rdata[ST_W-1:0] : '0;

    ibrd_ram #(.WIDTH(PROB_W), .DEPTH(MODEL_STATES)) u_prob_ram (
        .clk   (clk),
        .we    (prob_we),
        .waddr (item.address[ST_W-1:0]),
        .wdata (item.table_value),
        .raddr (st_s1),
        .rdata (prob_rdata)
    );

    assign trans_raddr = {st_s3_reg, bit_s3};

    ibrd_ram #(.WIDTH(STATE_W), .DEPTH(TR_DEPTH)) u_trans_ram (
        .clk   (clk),
        .we    (trans_op_we),
        .waddr (item.address[TR_W-1:0]),
        .wdata (item.table_value),
        .raddr (trans_raddr),
        .rdata (trans_rdata)
    );

    // stage 3: decide the bit, narrow and renormalize
    always_comb
    begin
        bit_s3    = (code_s3_reg >= rp_s3_reg);
        r_mid     = bit_s3 ? (range_s3_reg - rp_s3_reg) : rp_s3_reg;
        c_mid     = bit_s3 ? (code_s3_reg - rp_s3_reg) : code_s3_reg;
        below_one = (r_mid < RENORM_ONE);
        below_two = (r_mid < RENORM_TWO);
        used_s3   = USED_W'({1'b0, below_one}) + USED_W'({1'b0, below_two});
        if (below_two)
        begin
            r_new = {r_mid[RANGE_W-17:0], 16'h0000};
            c_new = {c_mid[RANGE_W-17:0], refill_s3_reg};
        end
        else if (below_one)
        begin
            r_new = {r_mid[RANGE_W-9:0], 8'h00};
            c_new = {c_mid[RANGE_W-9:0], refill_s3_reg[REFILL_W-1:8]};
        end
        else
        begin
            r_new = r_mid;
            c_new = c_mid;
        end
        tree_bit = {cx_s3_reg, bit_s3};
    end

    always_comb
    begin
        res_valid        = s3_valid_reg;
        res.decoded_bit  = bit_s3;
        res.lane         = LANE_OUT_W'(lane_s3_reg);
        res.bytes_used   = used_s3;
        res.byte_done    = (bit_cnt_reg == BIT_LAST);
        res.decoded_byte = (bit_cnt_reg == BIT_LAST) ? tree_bit[BYTE_W-1:0] : '0;
    end

    always_comb
    begin
        tree_next     = (bit_cnt_reg == BIT_LAST) ? TREE_ROOT : tree_bit;
        lane_cnt_next = (lane_cnt_reg == LANE_W'(LANES - 1)) ? '0 : lane_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_reg       <= TREE_ROOT;
            lane_cnt_reg   <= '0;
            bit_cnt_reg    <= '0;
            lane_valid_reg <= '0;
            ctx_valid_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            if (lane_we)
            begin
                lane_valid_reg[lane_waddr] <= 1'b1;
            end
            if (s4_valid_reg)
            begin
                ctx_valid_reg[cx_s4_reg] <= 1'b1;
            end
            if (s3_valid_reg)
            begin
                tree_reg     <= tree_next;
                lane_cnt_reg <= lane_cnt_next;
                bit_cnt_reg  <= bit_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 0 -> 1: capture addresses and valid bits alongside the reads
        lane_s1_reg     <= lane_cnt_reg;
        cx_s1_reg       <= cx_now;
        refill_s1_reg   <= item.refill_bytes;
        lane_vld_s1_reg <= lane_valid_reg[lane_cnt_reg];
        ctx_vld_s1_reg  <= ctx_valid_reg[cx_now];
        // stage 1 -> 2
        lane_s2_reg     <= lane_s1_reg;
        cx_s2_reg       <= cx_s1_reg;
        refill_s2_reg   <= refill_s1_reg;
        st_s2_reg       <= st_s1;
        range_s2_reg    <= lane_vld_s1_reg ? lane_rdata[2*RANGE_W-1:RANGE_W] : RANGE_FULL;
        code_s2_reg     <= lane_vld_s1_reg ? lane_rdata[RANGE_W-1:0] : '0;
        // stage 2 -> 3: scaled probability
        lane_s3_reg     <= lane_s2_reg;
        cx_s3_reg       <= cx_s2_reg;
        refill_s3_reg   <= refill_s2_reg;
        st_s3_reg       <= st_s2_reg;
        range_s3_reg    <= range_s2_reg;
        code_s3_reg     <= code_s2_reg;
        rp_s3_reg       <= RANGE_W'(range_s2_reg[RANGE_W-1:PROB_SHIFT]) * RANGE_W'(prob_rdata);
        // stage 3 -> 4: context write-back address
        cx_s4_reg       <= cx_s3_reg;
    end

    a_one_decode: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({start, s1_valid_reg, s2_valid_reg, s3_valid_reg}))
        else $error("two decodes overlap in the pipeline");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##3 res_valid)
        else $error("decode result not produced three cycles after start");

    a_ctx_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && start) |-> (cx_s4_reg != cx_now))
        else $error("context read and write-back hit the same entry");

    a_lane_port: assert property (@(posedge clk) disable iff (!rst_n)
        load_op |-> !s3_valid_reg)
        else $error("lane load collides with decode write-back");

endmodule

// ----- design/interleaved_binary_range_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interleaved_binary_range_decoder_core
// Round-robin multi-lane binary range decoder with bit-tree context model.
// ----------------------------------------------------------------------------
// Every accepted item returns exactly one result. Table writes and lane loads
// finish on acceptance. A decode runs in order through: context state RAM read,
// probability RAM read, scale multiply, then compare/renormalize with lane
// write-back and transition RAM read; the next decode may start right after,
// since its tree context comes from this bit. The transition lookup and the
// context write-back finish in a further stage that overlaps the next item.
// Results sit in a two-entry output buffer, so input keeps flowing through
// master-side stalls until both entries are held; then s_tready drops until a
// result transfers. Lane and context state reset at once through per-entry
// valid bits; the probability and transition tables must be written before a
// decode uses an entry.
module interleaved_binary_range_decoder_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // address[15:0], table_value[30:16], initial_code[62:31],
    // refill_bytes[78:63], zero pad[79]
    input  logic [ibrd_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // decoded_bit[0], lane[6:1], bytes_used[8:7], decoded_byte[16:9],
    // zero pad[23:17]
    output logic [ibrd_pkg::M_TDATA_W-1:0] m_tdata,
    // byte_done
    output logic                           m_tlast
);
    import ibrd_pkg::*;

    ibrd_item_t   item;
    ibrd_result_t pipe_res, push_data, head;
    logic         accept, busy, space, pipe_valid, push;

    always_comb
    begin
        item.op           = ibrd_op_t'(s_tuser);
        item.address      = s_tdata[15:0];
        item.table_value  = s_tdata[30:16];
        item.initial_code = s_tdata[62:31];
        item.refill_bytes = s_tdata[78:63];
    end

    assign s_tready = !busy && space;
    assign accept   = s_tvalid && s_tready;

    ibrd_bit_pipe u_bit_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (accept),
        .item        (item),
        .busy        (busy),
        .res_valid   (pipe_valid),
        .res         (pipe_res)
    );

    // non-decode items answer with an all-zero result on acceptance
    assign push      = pipe_valid || (accept && (item.op != OP_DECODE));
    assign push_data = pipe_valid ? pipe_res : '0;

    ibrd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head)
    );

    assign m_tdata = {7'b0, head.decoded_byte, head.bytes_used, head.lane, head.decoded_bit};
    assign m_tlast = head.byte_done;

endmodule
